FILE: src/dsf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsf_pkg
// Shared types, constants and helpers of the damped spring force block.
// ----------------------------------------------------------------------------
package dsf_pkg;

  // default depth of the queue between front and back
  localparam int unsigned QueueDepth = 4;

  // sine polynomial coefficients, Q30
  localparam logic [30:0] SinA = 31'd1686629713;
  localparam logic [29:0] SinB = 30'd688904866;
  localparam logic [26:0] SinC = 27'd76016977;

  localparam logic signed [71:0] S32Max = 72'sd2147483647;
  localparam logic signed [71:0] S32Min = -72'sd2147483648;

  typedef enum logic [2:0] {
    RegStiffness = 3'd0,
    RegDamping   = 3'd1,
    RegRestLen   = 3'd2,
    RegAnc1X     = 3'd3,
    RegAnc1Y     = 3'd4,
    RegAnc2X     = 3'd5,
    RegAnc2Y     = 3'd6,
    RegRigid     = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [30:0] stiffness;
    logic [30:0] damping;
    logic [30:0] rest_len;
    logic [31:0] anc1_x;
    logic [31:0] anc1_y;
    logic [31:0] anc2_x;
    logic [31:0] anc2_y;
    logic [1:0]  rigid;
  } cfg_t;

  typedef struct packed {
    logic [31:0] pos_one_x;
    logic [31:0] pos_one_y;
    logic [15:0] angle_one;
    logic [31:0] vel_one_x;
    logic [31:0] vel_one_y;
    logic [31:0] spin_one;
    logic [31:0] pos_two_x;
    logic [31:0] pos_two_y;
    logic [15:0] angle_two;
    logic [31:0] vel_two_x;
    logic [31:0] vel_two_y;
    logic [31:0] spin_two;
  } in_t;

  // classified request handed from front to back
  typedef struct packed {
    logic [31:0] vel_one_x;
    logic [31:0] vel_one_y;
    logic [31:0] spin_one;
    logic [31:0] vel_two_x;
    logic [31:0] vel_two_y;
    logic [31:0] spin_two;
    logic [31:0] w1x;
    logic [31:0] w1y;
    logic [31:0] w2x;
    logic [31:0] w2y;
    logic [33:0] dx;
    logic [33:0] dy;
    logic        skip;
  } job_t;

  typedef struct packed {
    logic [31:0] force_one_x;
    logic [31:0] force_one_y;
    logic [31:0] torque_one;
    logic [31:0] force_two_x;
    logic [31:0] force_two_y;
    logic [31:0] torque_two;
    logic        skipped;
  } res_t;

  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    logic signed [31:0] r;
    if (v > S32Max) begin
      r = 32'sh7fffffff;
    end else if (v < S32Min) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: src/dsf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsf_front
// Rotates both anchors, forms the anchor separation and flags coincidence.
// ----------------------------------------------------------------------------
module dsf_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  dsf_pkg::cfg_t cfg_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  dsf_pkg::in_t  in_i,
  input  logic          room_i,
  output logic          push_o,
  output dsf_pkg::job_t job_o
);

  localparam int unsigned Stages = 8;
  localparam int unsigned Lanes  = 4;

  logic [Stages-1:0]   vld_q;
  logic                en;
  dsf_pkg::in_t        in_q [Stages-1];
  logic signed [17:0]  sc [Lanes];
  logic signed [49:0]  m_q [8];
  logic signed [50:0]  rd [4];
  logic signed [31:0]  w_q [4];
  dsf_pkg::job_t       job_q;

  assign en         = room_i | ~vld_q[Stages-1];
  assign in_ready_o = en;
  assign push_o     = en & vld_q[Stages-1];
  assign job_o      = job_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Stages-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_q[0] <= in_i;
      for (int s = 1; s < Stages - 1; s++) begin
        in_q[s] <= in_q[s-1];
      end
    end
  end

  // lanes: sin one, cos one, sin two, cos two
  for (genvar l = 0; l < Lanes; l++) begin : g_lane
    logic [15:0]        ang;
    logic [14:0]        tf;
    logic [29:0]        tt;
    logic [41:0]        cp;
    logic [44:0]        up;
    logic [45:0]        wp;
    logic [1:0]         q2_q, q3_q, q4_q;
    logic [14:0]        t2_q, t3_q, t4_q;
    logic [14:0]        sq2_q, sq3_q;
    logic [29:0]        u_q;
    logic [30:0]        w4_q;
    logic signed [17:0] sc_q;

    assign ang = ((l < 2) ? in_q[0].angle_one : in_q[0].angle_two)
               + (((l % 2) == 1) ? 16'd16384 : 16'd0);
    assign tf  = ang[14] ? (15'd16384 - {1'b0, ang[13:0]}) : {1'b0, ang[13:0]};
    assign tt  = 30'(tf) * 30'(tf);
    assign cp  = 42'(dsf_pkg::SinC) * 42'(sq2_q);
    assign up  = 45'(u_q) * 45'(sq3_q);
    assign wp  = 46'(w4_q) * 46'(t4_q);

    always_ff @(posedge clk_i) begin
      if (en) begin
        q2_q  <= ang[15:14];
        t2_q  <= tf;
        sq2_q <= tt[28:14];
        q3_q  <= q2_q;
        t3_q  <= t2_q;
        sq3_q <= sq2_q;
        u_q   <= dsf_pkg::SinB - 30'(cp[41:14]);
        q4_q  <= q3_q;
        t4_q  <= t3_q;
        w4_q  <= dsf_pkg::SinA - up[44:14];
        sc_q  <= q4_q[1] ? -$signed(wp[45:28]) : $signed(wp[45:28]);
      end
    end

    assign sc[l] = sc_q;
  end

  // rotation products
  always_ff @(posedge clk_i) begin
    if (en) begin
      m_q[0] <= 50'($signed(cfg_i.anc1_x)) * 50'(sc[1]);
      m_q[1] <= 50'($signed(cfg_i.anc1_y)) * 50'(sc[0]);
      m_q[2] <= 50'($signed(cfg_i.anc1_x)) * 50'(sc[0]);
      m_q[3] <= 50'($signed(cfg_i.anc1_y)) * 50'(sc[1]);
      m_q[4] <= 50'($signed(cfg_i.anc2_x)) * 50'(sc[3]);
      m_q[5] <= 50'($signed(cfg_i.anc2_y)) * 50'(sc[2]);
      m_q[6] <= 50'($signed(cfg_i.anc2_x)) * 50'(sc[2]);
      m_q[7] <= 50'($signed(cfg_i.anc2_y)) * 50'(sc[3]);
    end
  end

  assign rd[0] = 51'(m_q[0]) - 51'(m_q[1]);
  assign rd[1] = 51'(m_q[2]) + 51'(m_q[3]);
  assign rd[2] = 51'(m_q[4]) - 51'(m_q[5]);
  assign rd[3] = 51'(m_q[6]) + 51'(m_q[7]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        w_q[i] <= dsf_pkg::sat32(72'(rd[i] >>> 16));
      end
    end
  end

  // separation of the two anchors
  logic signed [33:0] dx, dy;
  assign dx = 34'($signed(in_q[Stages-2].pos_two_x)) + 34'(w_q[2])
            - 34'($signed(in_q[Stages-2].pos_one_x)) - 34'(w_q[0]);
  assign dy = 34'($signed(in_q[Stages-2].pos_two_y)) + 34'(w_q[3])
            - 34'($signed(in_q[Stages-2].pos_one_y)) - 34'(w_q[1]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      job_q.vel_one_x <= in_q[Stages-2].vel_one_x;
      job_q.vel_one_y <= in_q[Stages-2].vel_one_y;
      job_q.spin_one  <= in_q[Stages-2].spin_one;
      job_q.vel_two_x <= in_q[Stages-2].vel_two_x;
      job_q.vel_two_y <= in_q[Stages-2].vel_two_y;
      job_q.spin_two  <= in_q[Stages-2].spin_two;
      job_q.w1x       <= w_q[0];
      job_q.w1y       <= w_q[1];
      job_q.w2x       <= w_q[2];
      job_q.w2y       <= w_q[3];
      job_q.dx        <= dx;
      job_q.dy        <= dy;
      job_q.skip      <= (dx == '0) && (dy == '0);
    end
  end

endmodule

FILE: src/dsf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsf_queue
// Small first-in first-out queue of classified requests.
// ----------------------------------------------------------------------------
module dsf_queue #(
  parameter int unsigned Depth = dsf_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dsf_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output dsf_pkg::job_t job_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  dsf_pkg::job_t   mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

endmodule

FILE: src/dsf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsf_back
// Length, direction, spring and damping force and torques, fully pipelined.
// ----------------------------------------------------------------------------
module dsf_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  dsf_pkg::cfg_t cfg_i,
  input  logic          job_valid_i,
  output logic          pop_o,
  input  dsf_pkg::job_t job_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output dsf_pkg::res_t res_o
);

  localparam int unsigned IsqSteps = 32;
  localparam int unsigned DivSteps = 31;
  localparam int unsigned Stages   = 4 + IsqSteps + DivSteps + 9;

  typedef struct packed {
    logic [31:0] w1x;
    logic [31:0] w1y;
    logic [31:0] w2x;
    logic [31:0] w2y;
    logic [31:0] rvx;
    logic [31:0] rvy;
    logic [30:0] sx;
    logic [30:0] sy;
    logic [1:0]  k;
    logic        sgnx;
    logic        sgny;
    logic        skip;
  } carry_t;

  logic [Stages-1:0] vld_q;
  logic              en;
  logic              r1, r2;

  assign en          = ~vld_q[Stages-1] | out_ready_i;
  assign pop_o       = en & job_valid_i;
  assign out_valid_o = vld_q[Stages-1];
  assign r1          = cfg_i.rigid[0];
  assign r2          = cfg_i.rigid[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Stages-2:0], job_valid_i};
    end
  end

  // magnitudes, scaling and spin products
  dsf_pkg::job_t      job_q, job2_q, job3_q;
  logic [33:0]        ax, ay, mx;
  logic [1:0]         k;
  logic [30:0]        sx2_q, sy2_q;
  logic [1:0]         k2_q, k3_q;
  logic               sgnx2_q, sgny2_q, sgnx3_q, sgny3_q;
  logic signed [63:0] pa1_q, pb1_q, pa2_q, pb2_q;
  logic [30:0]        sx3_q, sy3_q;
  logic [61:0]        sqx_q, sqy_q;
  logic signed [31:0] v1x_q, v1y_q, v2x_q, v2y_q;
  logic signed [31:0] v1x, v1y, v2x, v2y;
  logic [62:0]        n4_q;
  carry_t             c4_q;

  assign ax = job_q.dx[33] ? 34'(-$signed(job_q.dx)) : job_q.dx;
  assign ay = job_q.dy[33] ? 34'(-$signed(job_q.dy)) : job_q.dy;
  assign mx = (ax > ay) ? ax : ay;

  always_comb begin
    priority if (mx[33]) begin
      k = 2'd3;
    end else if (mx[32]) begin
      k = 2'd2;
    end else if (mx[31]) begin
      k = 2'd1;
    end else begin
      k = 2'd0;
    end
  end

  assign v1x = r1 ? dsf_pkg::sat32(72'($signed(job2_q.vel_one_x))
                                  + 72'((-65'(pa1_q)) >>> 16)) : '0;
  assign v1y = r1 ? dsf_pkg::sat32(72'($signed(job2_q.vel_one_y))
                                  + 72'(pb1_q >>> 16)) : '0;
  assign v2x = r2 ? dsf_pkg::sat32(72'($signed(job2_q.vel_two_x))
                                  + 72'((-65'(pa2_q)) >>> 16)) : '0;
  assign v2y = r2 ? dsf_pkg::sat32(72'($signed(job2_q.vel_two_y))
                                  + 72'(pb2_q >>> 16)) : '0;

  always_ff @(posedge clk_i) begin
    if (en) begin
      job_q   <= job_i;
      job2_q  <= job_q;
      sx2_q   <= 31'(ax >> k);
      sy2_q   <= 31'(ay >> k);
      k2_q    <= k;
      sgnx2_q <= job_q.dx[33];
      sgny2_q <= job_q.dy[33];
      pa1_q   <= $signed(job_q.spin_one) * $signed(job_q.w1y);
      pb1_q   <= $signed(job_q.spin_one) * $signed(job_q.w1x);
      pa2_q   <= $signed(job_q.spin_two) * $signed(job_q.w2y);
      pb2_q   <= $signed(job_q.spin_two) * $signed(job_q.w2x);
      job3_q  <= job2_q;
      sx3_q   <= sx2_q;
      sy3_q   <= sy2_q;
      k3_q    <= k2_q;
      sgnx3_q <= sgnx2_q;
      sgny3_q <= sgny2_q;
      sqx_q   <= 62'(sx2_q) * 62'(sx2_q);
      sqy_q   <= 62'(sy2_q) * 62'(sy2_q);
      v1x_q   <= v1x;
      v1y_q   <= v1y;
      v2x_q   <= v2x;
      v2y_q   <= v2y;
      n4_q    <= 63'(sqx_q) + 63'(sqy_q);
      c4_q.w1x  <= job3_q.w1x;
      c4_q.w1y  <= job3_q.w1y;
      c4_q.w2x  <= job3_q.w2x;
      c4_q.w2y  <= job3_q.w2y;
      c4_q.rvx  <= dsf_pkg::sat32(72'(v2x_q) - 72'(v1x_q));
      c4_q.rvy  <= dsf_pkg::sat32(72'(v2y_q) - 72'(v1y_q));
      c4_q.sx   <= sx3_q;
      c4_q.sy   <= sy3_q;
      c4_q.k    <= k3_q;
      c4_q.sgnx <= sgnx3_q;
      c4_q.sgny <= sgny3_q;
      c4_q.skip <= job3_q.skip;
    end
  end

  // integer square root, one result bit per stage
  logic [62:0] sq_rem [IsqSteps+1];
  logic [62:0] sq_res [IsqSteps+1];
  carry_t      sq_c   [IsqSteps+1];

  assign sq_rem[0] = n4_q;
  assign sq_res[0] = '0;
  assign sq_c[0]   = c4_q;

  for (genvar i = 0; i < IsqSteps; i++) begin : g_isq
    localparam logic [62:0] Bit = 63'(1) << (62 - 2 * i);
    logic [62:0] trial;
    logic [62:0] rem_q, res_q;
    carry_t      c_q;

    assign trial = sq_res[i] + Bit;

    always_ff @(posedge clk_i) begin
      if (en) begin
        if (sq_rem[i] >= trial) begin
          rem_q <= sq_rem[i] - trial;
          res_q <= (sq_res[i] >> 1) + Bit;
        end else begin
          rem_q <= sq_rem[i];
          res_q <= sq_res[i] >> 1;
        end
        c_q <= sq_c[i];
      end
    end

    assign sq_rem[i+1] = rem_q;
    assign sq_res[i+1] = res_q;
    assign sq_c[i+1]   = c_q;
  end

  // direction: two restoring dividers, one quotient bit per stage
  logic [60:0] dv_rx [DivSteps+1];
  logic [60:0] dv_ry [DivSteps+1];
  logic [30:0] dv_qx [DivSteps+1];
  logic [30:0] dv_qy [DivSteps+1];
  logic [31:0] dv_ds [DivSteps+1];
  carry_t      dv_c  [DivSteps+1];

  assign dv_rx[0] = {sq_c[IsqSteps].sx, 30'b0};
  assign dv_ry[0] = {sq_c[IsqSteps].sy, 30'b0};
  assign dv_qx[0] = '0;
  assign dv_qy[0] = '0;
  assign dv_ds[0] = sq_res[IsqSteps][31:0];
  assign dv_c[0]  = sq_c[IsqSteps];

  for (genvar j = 0; j < DivSteps; j++) begin : g_div
    localparam int unsigned Sh = DivSteps - 1 - j;
    logic [62:0] dsh;
    logic        gex, gey;
    logic [60:0] rx_q, ry_q;
    logic [30:0] qx_q, qy_q;
    logic [31:0] ds_q;
    carry_t      c_q;

    assign dsh = 63'(dv_ds[j]) << Sh;
    assign gex = 63'(dv_rx[j]) >= dsh;
    assign gey = 63'(dv_ry[j]) >= dsh;

    always_ff @(posedge clk_i) begin
      if (en) begin
        rx_q <= gex ? 61'(63'(dv_rx[j]) - dsh) : dv_rx[j];
        ry_q <= gey ? 61'(63'(dv_ry[j]) - dsh) : dv_ry[j];
        qx_q <= {dv_qx[j][29:0], gex};
        qy_q <= {dv_qy[j][29:0], gey};
        ds_q <= dv_ds[j];
        c_q  <= dv_c[j];
      end
    end

    assign dv_rx[j+1] = rx_q;
    assign dv_ry[j+1] = ry_q;
    assign dv_qx[j+1] = qx_q;
    assign dv_qy[j+1] = qy_q;
    assign dv_ds[j+1] = ds_q;
    assign dv_c[j+1]  = c_q;
  end

  // force and torque
  carry_t             cin;
  logic [35:0]        spn;
  logic signed [36:0] ext_raw;
  assign cin     = dv_c[DivSteps];
  assign spn     = 36'(dv_ds[DivSteps]) << cin.k;
  assign ext_raw = $signed({1'b0, spn}) - $signed({6'b0, cfg_i.rest_len});

  carry_t             e1_c, e2_c, e3_c, e4_c, e5_c, e6_c, e7_c, e8_c;
  logic signed [31:0] dirx1_q, diry1_q, ext1_q;
  logic signed [31:0] dirx2_q, diry2_q, dirx3_q, diry3_q, dirx4_q, diry4_q;
  logic signed [31:0] dirx5_q, diry5_q;
  logic signed [63:0] vpx_q, vpy_q, sp_q;
  logic signed [64:0] vsum;
  logic signed [31:0] vd_q;
  logic signed [47:0] spr3_q, spr4_q;
  logic signed [63:0] dp_q;
  logic signed [63:0] dsh_d;
  logic signed [31:0] f_q;
  logic signed [63:0] fpx_q, fpy_q;
  logic signed [31:0] fx7, fy7;
  logic signed [31:0] fx_q, fy_q, nx_q, ny_q;
  logic signed [31:0] fx8_q, fy8_q, nx8_q, ny8_q;
  logic signed [63:0] t1a_q, t1b_q, t2a_q, t2b_q;
  logic signed [64:0] td1, td2;
  dsf_pkg::res_t      res_q;

  assign vsum  = 65'(vpx_q) + 65'(vpy_q);
  assign dsh_d = dp_q >>> 16;
  assign fx7   = dsf_pkg::sat32(72'(fpx_q >>> 30));
  assign fy7   = dsf_pkg::sat32(72'(fpy_q >>> 30));
  assign td1   = 65'(t1a_q) - 65'(t1b_q);
  assign td2   = 65'(t2a_q) - 65'(t2b_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      e1_c    <= cin;
      dirx1_q <= cin.sgnx ? -$signed({1'b0, dv_qx[DivSteps]})
                          : $signed({1'b0, dv_qx[DivSteps]});
      diry1_q <= cin.sgny ? -$signed({1'b0, dv_qy[DivSteps]})
                          : $signed({1'b0, dv_qy[DivSteps]});
      ext1_q  <= dsf_pkg::sat32(72'(ext_raw));

      e2_c    <= e1_c;
      dirx2_q <= dirx1_q;
      diry2_q <= diry1_q;
      vpx_q   <= $signed(e1_c.rvx) * dirx1_q;
      vpy_q   <= $signed(e1_c.rvy) * diry1_q;
      sp_q    <= $signed({1'b0, cfg_i.stiffness}) * ext1_q;

      e3_c    <= e2_c;
      dirx3_q <= dirx2_q;
      diry3_q <= diry2_q;
      vd_q    <= dsf_pkg::sat32(72'(vsum >>> 30));
      spr3_q  <= 48'(sp_q >>> 16);

      e4_c    <= e3_c;
      dirx4_q <= dirx3_q;
      diry4_q <= diry3_q;
      spr4_q  <= spr3_q;
      dp_q    <= $signed({1'b0, cfg_i.damping}) * vd_q;

      e5_c    <= e4_c;
      dirx5_q <= dirx4_q;
      diry5_q <= diry4_q;
      f_q     <= dsf_pkg::sat32(72'(spr4_q) + 72'(dsh_d));

      e6_c    <= e5_c;
      fpx_q   <= f_q * dirx5_q;
      fpy_q   <= f_q * diry5_q;

      e7_c    <= e6_c;
      fx_q    <= fx7;
      fy_q    <= fy7;
      nx_q    <= dsf_pkg::sat32(-72'(fx7));
      ny_q    <= dsf_pkg::sat32(-72'(fy7));

      e8_c    <= e7_c;
      fx8_q   <= fx_q;
      fy8_q   <= fy_q;
      nx8_q   <= nx_q;
      ny8_q   <= ny_q;
      t1a_q   <= $signed(e7_c.w1x) * fy_q;
      t1b_q   <= $signed(e7_c.w1y) * fx_q;
      t2a_q   <= $signed(e7_c.w2x) * ny_q;
      t2b_q   <= $signed(e7_c.w2y) * nx_q;

      res_q.skipped <= e8_c.skip;
      if (!e8_c.skip && r1) begin
        res_q.force_one_x <= fx8_q;
        res_q.force_one_y <= fy8_q;
        res_q.torque_one  <= dsf_pkg::sat32(72'(td1 >>> 16));
      end else begin
        res_q.force_one_x <= '0;
        res_q.force_one_y <= '0;
        res_q.torque_one  <= '0;
      end
      if (!e8_c.skip && r2) begin
        res_q.force_two_x <= nx8_q;
        res_q.force_two_y <= ny8_q;
        res_q.torque_two  <= dsf_pkg::sat32(72'(td2 >>> 16));
      end else begin
        res_q.force_two_x <= '0;
        res_q.force_two_y <= '0;
        res_q.torque_two  <= '0;
      end
    end
  end

  assign res_o = res_q;

endmodule

FILE: src/damped_spring_force_2d.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// damped_spring_force_2d
// Damped spring between two bodies: force and torque on each, one per cycle when neither side stalls.
// ----------------------------------------------------------------------------
// throughput: one spring per cycle while neither side stalls, set by the fully pipelined square root
//   (one bit per stage) and the two direction dividers (one bit per stage)
// reset: asynchronous, active low; clears all pipeline valids and the queue,
//   and loads the register defaults (stiffness 1.0, rigid mask 3, others 0)
module damped_spring_force_2d #(
  parameter int unsigned QueueDepth = dsf_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  // request side
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] pos_one_x_i,
  input  logic [31:0] pos_one_y_i,
  input  logic [15:0] angle_one_i,
  input  logic [31:0] vel_one_x_i,
  input  logic [31:0] vel_one_y_i,
  input  logic [31:0] spin_one_i,
  input  logic [31:0] pos_two_x_i,
  input  logic [31:0] pos_two_y_i,
  input  logic [15:0] angle_two_i,
  input  logic [31:0] vel_two_x_i,
  input  logic [31:0] vel_two_y_i,
  input  logic [31:0] spin_two_i,
  // result side
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] force_one_x_o,
  output logic [31:0] force_one_y_o,
  output logic [31:0] torque_one_o,
  output logic [31:0] force_two_x_o,
  output logic [31:0] force_two_y_o,
  output logic [31:0] torque_two_o,
  output logic        skipped_o
);

  // configuration registers
  dsf_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stiffness <= 31'd65536;
      cfg_q.damping   <= '0;
      cfg_q.rest_len  <= '0;
      cfg_q.anc1_x    <= '0;
      cfg_q.anc1_y    <= '0;
      cfg_q.anc2_x    <= '0;
      cfg_q.anc2_y    <= '0;
      cfg_q.rigid     <= 2'b11;
    end else if (cfg_we_i) begin
      unique case (dsf_pkg::reg_idx_e'(cfg_idx_i))
        dsf_pkg::RegStiffness: cfg_q.stiffness <= cfg_data_i[30:0];
        dsf_pkg::RegDamping:   cfg_q.damping   <= cfg_data_i[30:0];
        dsf_pkg::RegRestLen:   cfg_q.rest_len  <= cfg_data_i[30:0];
        dsf_pkg::RegAnc1X:     cfg_q.anc1_x    <= cfg_data_i;
        dsf_pkg::RegAnc1Y:     cfg_q.anc1_y    <= cfg_data_i;
        dsf_pkg::RegAnc2X:     cfg_q.anc2_x    <= cfg_data_i;
        dsf_pkg::RegAnc2Y:     cfg_q.anc2_y    <= cfg_data_i;
        dsf_pkg::RegRigid:     cfg_q.rigid     <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // gather the request fields
  dsf_pkg::in_t req;
  assign req.pos_one_x = pos_one_x_i;
  assign req.pos_one_y = pos_one_y_i;
  assign req.angle_one = angle_one_i;
  assign req.vel_one_x = vel_one_x_i;
  assign req.vel_one_y = vel_one_y_i;
  assign req.spin_one  = spin_one_i;
  assign req.pos_two_x = pos_two_x_i;
  assign req.pos_two_y = pos_two_y_i;
  assign req.angle_two = angle_two_i;
  assign req.vel_two_x = vel_two_x_i;
  assign req.vel_two_y = vel_two_y_i;
  assign req.spin_two  = spin_two_i;

  // front: anchor rotation, separation, coincidence check
  logic          q_full, q_push, q_valid, q_pop;
  dsf_pkg::job_t push_job, pop_job;

  dsf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (req),
    .room_i     (~q_full),
    .push_o     (q_push),
    .job_o      (push_job)
  );

  // queue decouples front stalls from back stalls
  dsf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .job_o   (pop_job)
  );

  // back: length, direction, forces and torques; last stage is the output register
  dsf_pkg::res_t res;

  dsf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (q_valid),
    .pop_o       (q_pop),
    .job_i       (pop_job),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign force_one_x_o = res.force_one_x;
  assign force_one_y_o = res.force_one_y;
  assign torque_one_o  = res.torque_one;
  assign force_two_x_o = res.force_two_x;
  assign force_two_y_o = res.force_two_y;
  assign torque_two_o  = res.torque_two;
  assign skipped_o     = res.skipped;

endmodule

FILE: test/spring_force_compare.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spring_force_compare
// Watches the configuration port and both channels of the spring block,
// predicts each result and compares it with what comes out.
// ----------------------------------------------------------------------------
module spring_force_compare (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [31:0]   cfg_data_i,
  input  logic          in_valid_i,
  input  logic          in_ready_i,
  input  dsf_pkg::in_t  req_i,
  input  logic          out_valid_i,
  input  logic          out_ready_i,
  input  dsf_pkg::res_t res_i,
  output int            mismatch_count_o,
  output int            pending_o
);

  typedef logic signed [127:0] wide_t;

  localparam longint SinAL = 1686629713;
  localparam longint SinBL = 2 * SinAL - 64'sd2684354560;
  localparam longint SinCL = SinAL - 64'sd1610612736;

  longint unsigned stiff_q, damp_q, rest_q;
  longint          a1x_q, a1y_q, a2x_q, a2y_q;
  logic [1:0]      rigid_q;
  dsf_pkg::res_t   pending_forces[$];

  function automatic longint clamp32(input wide_t v);
    longint r;
    if (v > 128'sd2147483647) begin
      r = 64'sd2147483647;
    end else if (v < -128'sd2147483648) begin
      r = -64'sd2147483648;
    end else begin
      r = longint'(v);
    end
    return r;
  endfunction

  function automatic longint sx32(input logic [31:0] u);
    return longint'(signed'(u));
  endfunction

  function automatic longint sine_q16(input logic [15:0] a);
    longint t, t2, u, w, r;
    t = longint'(a[13:0]);
    if (a[14]) begin
      t = 16384 - t;
    end
    t2 = (t * t) >>> 14;
    u  = SinBL - ((SinCL * t2) >>> 14);
    w  = SinAL - ((u * t2) >>> 14);
    r  = (w * t) >>> 28;
    return a[15] ? -r : r;
  endfunction

  function automatic longint unsigned root64(input longint unsigned n);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic void turn(input longint x, input longint y, input logic [15:0] ang,
                               output longint wx, output longint wy);
    longint s, c;
    s  = sine_q16(ang);
    c  = sine_q16(ang + 16'd16384);
    wx = clamp32(wide_t'((x * c - y * s) >>> 16));
    wy = clamp32(wide_t'((x * s + y * c) >>> 16));
  endfunction

  function automatic longint lever_torque(input longint wx, input longint wy,
                                          input longint fx, input longint fy);
    wide_t p;
    p = (wide_t'(wx) * wide_t'(fy) - wide_t'(wy) * wide_t'(fx)) >>> 16;
    return clamp32(p);
  endfunction

  function automatic dsf_pkg::res_t calc_spring_result(input dsf_pkg::in_t r);
    dsf_pkg::res_t   o;
    longint          w1x, w1y, w2x, w2y, dx, dy, ax, ay, m, dirx, diry, span;
    longint          v1x, v1y, v2x, v2y, rvx, rvy, vd, ext, f, fx, fy, sp;
    longint unsigned ds;
    int              k;
    o = '0;
    v1x = 0; v1y = 0; v2x = 0; v2y = 0;
    turn(a1x_q, a1y_q, r.angle_one, w1x, w1y);
    turn(a2x_q, a2y_q, r.angle_two, w2x, w2y);
    dx = (sx32(r.pos_two_x) + w2x) - (sx32(r.pos_one_x) + w1x);
    dy = (sx32(r.pos_two_y) + w2y) - (sx32(r.pos_one_y) + w1y);
    if (dx == 0 && dy == 0) begin
      o.skipped = 1'b1;
      return o;
    end
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    m  = ax > ay ? ax : ay;
    k  = 0;
    while ((m >>> k) >= 64'sd2147483648) k++;
    ax = ax >>> k;
    ay = ay >>> k;
    ds   = root64(longint'(ax * ax) + longint'(ay * ay));
    span = longint'(ds) <<< k;
    dirx = longint'((longint'(ax) << 30) / ds);
    diry = longint'((longint'(ay) << 30) / ds);
    if (dx < 0) dirx = -dirx;
    if (dy < 0) diry = -diry;
    if (rigid_q[0]) begin
      sp  = sx32(r.spin_one);
      v1x = clamp32(wide_t'(sx32(r.vel_one_x) + ((-sp * w1y) >>> 16)));
      v1y = clamp32(wide_t'(sx32(r.vel_one_y) + ((sp * w1x) >>> 16)));
    end
    if (rigid_q[1]) begin
      sp  = sx32(r.spin_two);
      v2x = clamp32(wide_t'(sx32(r.vel_two_x) + ((-sp * w2y) >>> 16)));
      v2y = clamp32(wide_t'(sx32(r.vel_two_y) + ((sp * w2x) >>> 16)));
    end
    rvx = clamp32(wide_t'(v2x - v1x));
    rvy = clamp32(wide_t'(v2y - v1y));
    vd  = clamp32((wide_t'(rvx) * dirx + wide_t'(rvy) * diry) >>> 30);
    ext = clamp32(wide_t'(span - longint'(rest_q)));
    f   = clamp32(((wide_t'(stiff_q) * ext) >>> 16) + ((wide_t'(damp_q) * vd) >>> 16));
    fx  = clamp32((wide_t'(f) * dirx) >>> 30);
    fy  = clamp32((wide_t'(f) * diry) >>> 30);
    if (rigid_q[0]) begin
      o.force_one_x = fx[31:0];
      o.force_one_y = fy[31:0];
      o.torque_one  = 32'(lever_torque(w1x, w1y, fx, fy));
    end
    if (rigid_q[1]) begin
      o.force_two_x = 32'(clamp32(-wide_t'(fx)));
      o.force_two_y = 32'(clamp32(-wide_t'(fy)));
      o.torque_two  = 32'(lever_torque(w2x, w2y, clamp32(-wide_t'(fx)),
                                       clamp32(-wide_t'(fy))));
    end
    return o;
  endfunction

  assign pending_o = pending_forces.size();

  // sampled mid-cycle so every value is settled; the handshake completes at
  // the following rising edge
  always @(negedge clk_i or negedge rst_ni) begin
    dsf_pkg::res_t want;
    logic [31:0]   got_f[7];
    logic [31:0]   want_f[7];
    string         names[7];
    if (!rst_ni) begin
      stiff_q = 65536; damp_q = 0; rest_q = 0;
      a1x_q = 0; a1y_q = 0; a2x_q = 0; a2y_q = 0;
      rigid_q = 2'd3;
      pending_forces.delete();
      mismatch_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (dsf_pkg::reg_idx_e'(cfg_idx_i))
          dsf_pkg::RegStiffness: stiff_q = 64'(cfg_data_i[30:0]);
          dsf_pkg::RegDamping:   damp_q  = 64'(cfg_data_i[30:0]);
          dsf_pkg::RegRestLen:   rest_q  = 64'(cfg_data_i[30:0]);
          dsf_pkg::RegAnc1X:     a1x_q   = sx32(cfg_data_i);
          dsf_pkg::RegAnc1Y:     a1y_q   = sx32(cfg_data_i);
          dsf_pkg::RegAnc2X:     a2x_q   = sx32(cfg_data_i);
          dsf_pkg::RegAnc2Y:     a2y_q   = sx32(cfg_data_i);
          dsf_pkg::RegRigid:     rigid_q = cfg_data_i[1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        pending_forces.push_back(calc_spring_result(req_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (pending_forces.size() == 0) begin
          if (mismatch_count_o < 10) begin
            $display("%0t: result with no request outstanding", $realtime);
          end
          mismatch_count_o++;
        end else begin
          want = pending_forces.pop_front();
          names  = '{"force_one_x", "force_one_y", "torque_one", "force_two_x",
                     "force_two_y", "torque_two", "skipped"};
          want_f = '{want.force_one_x, want.force_one_y, want.torque_one, want.force_two_x,
                     want.force_two_y, want.torque_two, {31'd0, want.skipped}};
          got_f  = '{res_i.force_one_x, res_i.force_one_y, res_i.torque_one,
                     res_i.force_two_x, res_i.force_two_y, res_i.torque_two,
                     {31'd0, res_i.skipped}};
          for (int i = 0; i < 7; i++) begin
            if (got_f[i] !== want_f[i]) begin
              if (mismatch_count_o < 10) begin
                $display("%0t: %s expected %h got %h", $realtime, names[i], want_f[i],
                         got_f[i]);
              end
              mismatch_count_o++;
            end
          end
        end
      end
    end
  end

endmodule

FILE: test/damped_spring_force_2d_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// damped_spring_force_2d_tb
// Drives spring requests through several register settings with random
// gaps and stalls; a separate compare module predicts and checks results.
// ----------------------------------------------------------------------------
module damped_spring_force_2d_tb;

  localparam int ItemsPerPhase = 160;
  localparam int NumPhases     = 8;
  localparam int StallLimit    = 5000;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          cfg_we = 1'b0;
  logic [2:0]    cfg_idx = '0;
  logic [31:0]   cfg_data = '0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  dsf_pkg::in_t  req = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  dsf_pkg::res_t res;
  int            mismatch_count, pending;
  int            sent = 0;
  int            idle_cycles = 0;
  logic          calm = 1'b0;      // no idling on either side in the last phase
  logic          hold_done = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  damped_spring_force_2d dut (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .pos_one_x_i(req.pos_one_x), .pos_one_y_i(req.pos_one_y), .angle_one_i(req.angle_one),
    .vel_one_x_i(req.vel_one_x), .vel_one_y_i(req.vel_one_y), .spin_one_i(req.spin_one),
    .pos_two_x_i(req.pos_two_x), .pos_two_y_i(req.pos_two_y), .angle_two_i(req.angle_two),
    .vel_two_x_i(req.vel_two_x), .vel_two_y_i(req.vel_two_y), .spin_two_i(req.spin_two),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .force_one_x_o(res.force_one_x), .force_one_y_o(res.force_one_y),
    .torque_one_o(res.torque_one), .force_two_x_o(res.force_two_x),
    .force_two_y_o(res.force_two_y), .torque_two_o(res.torque_two),
    .skipped_o(res.skipped)
  );

  spring_force_compare u_compare (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .req_i(req),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .res_i(res),
    .mismatch_count_o(mismatch_count), .pending_o(pending)
  );

  // watchdog: cycles without any handshake
  always @(negedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // result side: one long hold-off to back the pipe up, then random stall bursts
  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    out_ready <= 1'b1;
    while (sent < 200) @(posedge clk_i);
    out_ready <= 1'b0;
    repeat (400) @(posedge clk_i);
    out_ready <= 1'b1;
    hold_done <= 1'b1;
    forever begin
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
        out_ready <= 1'b1;
      end else begin
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  task automatic wait_drained();
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input dsf_pkg::reg_idx_e idx, input logic [31:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(input logic [30:0] st, input logic [30:0] dm, input logic [30:0] rl,
                           input logic [31:0] a1x, input logic [31:0] a1y,
                           input logic [31:0] a2x, input logic [31:0] a2y,
                           input logic [1:0] mask);
    write_reg(dsf_pkg::RegStiffness, {1'b0, st});
    write_reg(dsf_pkg::RegDamping, {1'b0, dm});
    write_reg(dsf_pkg::RegRestLen, {1'b0, rl});
    write_reg(dsf_pkg::RegAnc1X, a1x);
    write_reg(dsf_pkg::RegAnc1Y, a1y);
    write_reg(dsf_pkg::RegAnc2X, a2x);
    write_reg(dsf_pkg::RegAnc2Y, a2y);
    write_reg(dsf_pkg::RegRigid, {30'd0, mask});
  endtask

  // after an occasional random gap, offer one request and hold it until the block takes it
  task automatic send(input dsf_pkg::in_t item);
    logic took;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    req      <= item;
    in_valid <= 1'b1;
    do begin
      @(negedge clk_i);
      took = in_ready;
      @(posedge clk_i);
    end while (!took);
    sent++;
  endtask

  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0, 1: v = $urandom();
      2:    v = $urandom_range(0, 1) ? 32'h7fffffff - $urandom_range(0, 3)
                                     : 32'h80000000 + $urandom_range(0, 3);
      default: v = 32'(signed'($urandom_range(0, 1 << 22)) - (1 << 21));
    endcase
    return v;
  endfunction

  function automatic dsf_pkg::in_t random_item();
    dsf_pkg::in_t it;
    it.pos_one_x = pick_value(); it.pos_one_y = pick_value();
    it.vel_one_x = pick_value(); it.vel_one_y = pick_value();
    it.spin_one  = pick_value();
    it.pos_two_x = pick_value(); it.pos_two_y = pick_value();
    it.vel_two_x = pick_value(); it.vel_two_y = pick_value();
    it.spin_two  = pick_value();
    it.angle_one = 16'($urandom());
    it.angle_two = 16'($urandom());
    // coincident anchors when offsets are zero and positions match
    if ($urandom_range(0, 15) == 0) begin
      it.pos_two_x = it.pos_one_x;
      it.pos_two_y = it.pos_one_y;
    end
    return it;
  endfunction

  initial begin
    dsf_pkg::in_t it;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part under reset defaults: zero offsets, both rigid
    it = '0;
    send(it);                                        // coincident anchors
    it.pos_two_x = 32'h0001_0000;
    send(it);
    it.pos_two_x = 32'h7fffffff; it.pos_one_x = 32'h80000000;
    send(it);                                        // widest separation
    it.pos_two_y = 32'h80000000; it.pos_one_y = 32'h7fffffff;
    send(it);
    for (int a = 0; a < 5; a++) begin
      it = '0;
      it.pos_two_y = 32'h0003_0000;
      it.angle_one = 16'(a * 16384 - (a == 4));
      it.angle_two = 16'hffff - it.angle_one;
      it.spin_one  = a[0] ? 32'h7fffffff : 32'h80000000;
      it.spin_two  = a[0] ? 32'h80000000 : 32'h7fffffff;
      it.vel_one_x = 32'h80000000; it.vel_one_y = 32'h7fffffff;
      it.vel_two_x = 32'h7fffffff; it.vel_two_y = 32'h80000000;
      send(it);
    end
    it = '1;
    send(it);
    in_valid <= 1'b0;

    for (int ph = 0; ph < NumPhases; ph++) begin
      // configuration only with the pipe empty
      wait_drained();
      repeat (90) @(posedge clk_i);
      case (ph)
        0: ;
        1: write_all(31'h0001_0000, 31'h0000_8000, 31'h000a_0000, 32'h0002_0000,
                     32'hffff_0000, 32'hfffe_8000, 32'h0001_8000, 2'd3);
        2: write_all(31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 32'h7fffffff,
                     32'h80000000, 32'h80000000, 32'h7fffffff, 2'd1);
        3: write_all(31'h0, 31'h0, 31'h0, 32'h0, 32'h0, 32'h0, 32'h0, 2'd2);
        4: write_all(31'h0002_0000, 31'h0004_0000, 31'h0, 32'h0, 32'h0, 32'h0, 32'h0, 2'd0);
        default: write_all(31'($urandom()), 31'($urandom()), 31'($urandom_range(0, 1 << 24)),
                           pick_value(), pick_value(), pick_value(), pick_value(),
                           2'($urandom_range(0, 3)));
      endcase
      calm <= (ph == NumPhases - 1);
      for (int n = 0; n < ItemsPerPhase; n++) begin
        send(random_item());
        // sender waits out every outstanding result once, after the hold-off
        if (ph == 3 && n == 40) begin
          in_valid <= 1'b0;
          wait_drained();
        end
      end
      in_valid <= 1'b0;
    end

    wait_drained();
    repeat (100) @(posedge clk_i);
    if (mismatch_count == 0 && pending == 0 && hold_done) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: damped_spring_force_2d.f
src/dsf_pkg.sv
src/dsf_front.sv
src/dsf_queue.sv
src/dsf_back.sv
src/damped_spring_force_2d.sv
test/spring_force_compare.sv
test/damped_spring_force_2d_tb.sv
